// ===== src/aesp_pkg.sv =====
// aesp_pkg: shared types, codes and helpers for the escape sequence parser.
// No dependencies.
`default_nettype none
package aesp_pkg;

  localparam int CW = 6;

  typedef enum logic [3:0] {
    M_ECHO, M_ESC, M_CSI, M_CSIP, M_CSIQ, M_CSIQP, M_OSC, M_OSCP, M_TITLE
  } mode_t;

  typedef enum logic [1:0] {J_ONE, J_FB, J_SGR} job_kind_t;

  typedef enum logic [2:0] {B_IDLE, B_ONE, B_ESC, B_RD, B_CH, B_SGR, B_END} bstate_t;

  localparam logic [3:0] A_WRITE     = 4'd0;
  localparam logic [3:0] A_NEWLINE   = 4'd1;
  localparam logic [3:0] A_CR        = 4'd2;
  localparam logic [3:0] A_BS        = 4'd3;
  localparam logic [3:0] A_FWD       = 4'd4;
  localparam logic [3:0] A_POS       = 4'd5;
  localparam logic [3:0] A_ERASE_D   = 4'd6;
  localparam logic [3:0] A_ERASE_C   = 4'd7;
  localparam logic [3:0] A_RST_ATTR  = 4'd8;
  localparam logic [3:0] A_FG        = 4'd9;
  localparam logic [3:0] A_BG        = 4'd10;
  localparam logic [3:0] A_BLINK     = 4'd11;
  localparam logic [3:0] A_VISIBLE   = 4'd12;
  localparam logic [3:0] A_TITLE_CH  = 4'd13;
  localparam logic [3:0] A_TITLE_END = 4'd14;

  localparam logic [15:0] C_ESC  = 16'h001B;
  localparam logic [15:0] C_BEL  = 16'h0007;
  localparam logic [15:0] C_NL   = 16'h000A;
  localparam logic [15:0] C_CR   = 16'h000D;
  localparam logic [15:0] C_BS   = 16'h0008;
  localparam logic [15:0] C_LBR  = 16'h005B;
  localparam logic [15:0] C_RBR  = 16'h005D;
  localparam logic [15:0] C_QM   = 16'h003F;
  localparam logic [15:0] C_SEMI = 16'h003B;
  localparam logic [15:0] C_UC   = 16'h0043;
  localparam logic [15:0] C_UH   = 16'h0048;
  localparam logic [15:0] C_UJ   = 16'h004A;
  localparam logic [15:0] C_UX   = 16'h0058;
  localparam logic [15:0] C_LM   = 16'h006D;
  localparam logic [15:0] C_LH   = 16'h0068;
  localparam logic [15:0] C_LL   = 16'h006C;
  localparam logic [15:0] C_UE   = 16'h0045;
  localparam logic [15:0] C_US   = 16'h0053;
  localparam logic [15:0] COL_DEF = 16'd16;

  typedef struct packed {
    logic [3:0]  act;
    logic [15:0] a;
    logic [15:0] b;
  } res_t;

  typedef struct packed {
    job_kind_t   kind;
    res_t        res;
    logic [CW-1:0] cnt;
  } job_t;

  typedef struct packed {
    logic          we;
    logic [CW-1:0] addr;
    logic [15:0]   data;
  } seq_wr_t;

  typedef struct packed {
    logic store_done;
  } bstat_t;

  function automatic res_t echo_res(input logic [15:0] c);
    res_t r;
    r.a = 16'd0;
    r.b = 16'd0;
    case (c)
      C_NL:    r.act = A_NEWLINE;
      C_CR:    r.act = A_CR;
      C_BS:    r.act = A_BS;
      default: begin
        r.act = A_WRITE;
        r.a   = c;
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/aesp_jobq.sv =====
// aesp_jobq: two-entry job queue between parser front and action back end.
// Depends on aesp_pkg.
`default_nettype none
module aesp_jobq
  import aesp_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  push,
  input  job_t din,
  output logic full,
  input  wire  pop,
  output job_t dout,
  output logic empty
);

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= !wp_r;
      if (do_pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= din;
  end

endmodule
`default_nettype wire

// ===== src/aesp_front.sv =====
// aesp_front: takes characters, tracks the escape sequence and queues jobs.
// Depends on aesp_pkg; feeds aesp_jobq and the sequence store in aesp_back.
`default_nettype none
module aesp_front
  import aesp_pkg::*;
#(
  parameter int MAX_PARAMS = 16,
  parameter int SEQ_CHARS  = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_push,
  input  wire  [15:0]                  in_ch,
  output logic                         in_full,
  input  wire                          q_full,
  output logic                         q_push,
  output job_t                         q_job,
  output seq_wr_t                      seq_wr,
  output logic [MAX_PARAMS-1:0][15:0]  pvals,
  input  bstat_t                       bstat
);

  localparam int LW  = $clog2(SEQ_CHARS + 1);
  localparam int PW  = $clog2(MAX_PARAMS + 1);
  localparam int PIW = $clog2(MAX_PARAMS);

  mode_t                        mode_r, mode_nxt;
  logic [LW-1:0]                len_r, len_nxt, len_n, fb_len;
  logic [PW-1:0]                pcnt_r, pcnt_nxt, pcnt_m1;
  logic [15:0]                  acc_r, acc_nxt, acc_up;
  logic [MAX_PARAMS-1:0][15:0]  pstore_r;
  logic                         busy_r, busy_nxt;
  logic                         acc_en, in_seq, is_dig, is_fin, hl, fail, fin_csi, ovl;
  logic [19:0]                  t10;
  logic                         ps_we;
  logic [PIW-1:0]               ps_idx;
  logic [15:0]                  ps_dat, p0, p1, c;
  logic [PW-1:0]                fcnt;

  assign c       = in_ch;
  assign in_full = q_full || busy_r;
  assign acc_en  = in_push && !in_full;
  assign in_seq  = (mode_r != M_ECHO) && (mode_r != M_TITLE);
  assign is_dig  = (c >= 16'h0030) && (c <= 16'h0039);
  assign is_fin  = (c == C_UC) || (c == C_UH) || (c == C_UJ) || (c == C_UX) || (c == C_LM);
  assign hl      = (c == C_LH) || (c == C_LL);
  assign t10     = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {16'd0, c[3:0]};
  assign acc_up  = (t10 > 20'd65535) ? 16'hFFFF : t10[15:0];
  assign len_n   = len_r + LW'(1);
  assign fb_len  = (c == C_ESC) ? len_r : len_n;
  assign pcnt_m1 = pcnt_r - PW'(1);
  assign pvals   = pstore_r;

  // parameters seen by a final byte
  always_comb begin
    if (mode_r == M_CSI) begin
      p0   = 16'd0;
      p1   = 16'd0;
      fcnt = PW'(1);
    end else begin
      p0   = (pcnt_r == PW'(1)) ? acc_r : pstore_r[0];
      p1   = (pcnt_r < PW'(2)) ? 16'd0 : ((pcnt_r == PW'(2)) ? acc_r : pstore_r[1]);
      fcnt = pcnt_r;
    end
  end

  // next state
  always_comb begin
    mode_nxt = mode_r;
    fail     = 1'b0;
    fin_csi  = 1'b0;
    if (acc_en) begin
      case (mode_r)
        M_ECHO:  if (c == C_ESC) mode_nxt = M_ESC;
        M_TITLE: if (c == C_BEL) mode_nxt = M_ECHO;
        M_ESC: begin
          if (c == C_LBR) mode_nxt = M_CSI;
          else if (c == C_RBR) mode_nxt = M_OSC;
          else fail = 1'b1;
        end
        M_CSI: begin
          if (c == C_QM) mode_nxt = M_CSIQ;
          else if (is_fin) begin
            fin_csi  = 1'b1;
            mode_nxt = M_ECHO;
          end else if (is_dig) mode_nxt = M_CSIP;
          else fail = 1'b1;
        end
        M_CSIP: begin
          if (is_dig) mode_nxt = M_CSIP;
          else if (c == C_SEMI && pcnt_r < PW'(MAX_PARAMS)) mode_nxt = M_CSIP;
          else if (is_fin) begin
            fin_csi  = 1'b1;
            mode_nxt = M_ECHO;
          end else fail = 1'b1;
        end
        M_CSIQ: begin
          if (is_dig) mode_nxt = M_CSIQP;
          else fail = 1'b1;
        end
        M_CSIQP: begin
          if (is_dig) mode_nxt = M_CSIQP;
          else if (hl && (acc_r == 16'd12 || acc_r == 16'd25)) mode_nxt = M_ECHO;
          else fail = 1'b1;
        end
        M_OSC: begin
          if (is_dig) mode_nxt = M_OSCP;
          else fail = 1'b1;
        end
        M_OSCP: begin
          if (is_dig) mode_nxt = M_OSCP;
          else if (c == C_SEMI && (acc_r == 16'd0 || acc_r == 16'd2)) mode_nxt = M_TITLE;
          else fail = 1'b1;
        end
        default: mode_nxt = M_ECHO;
      endcase
      if (fail) mode_nxt = (c == C_ESC) ? M_ESC : M_ECHO;
    end
    ovl = acc_en && in_seq && !fail && (mode_nxt != M_ECHO) && (mode_nxt != M_TITLE)
          && (len_n >= LW'(SEQ_CHARS));
    if (ovl) mode_nxt = M_ECHO;
  end

  // jobs and parameter bookkeeping
  always_comb begin
    len_nxt     = len_r;
    pcnt_nxt    = pcnt_r;
    acc_nxt     = acc_r;
    ps_we       = 1'b0;
    ps_idx      = pcnt_m1[PIW-1:0];
    ps_dat      = acc_r;
    q_push      = 1'b0;
    q_job.kind  = J_ONE;
    q_job.res   = echo_res(c);
    q_job.cnt   = '0;
    seq_wr.we   = acc_en && in_seq;
    seq_wr.addr = CW'(len_r);
    seq_wr.data = c;
    if (acc_en) begin
      if (mode_r == M_ECHO) begin
        if (c == C_ESC) len_nxt = '0;
        else q_push = 1'b1;
      end else if (mode_r == M_TITLE) begin
        q_push        = 1'b1;
        q_job.res.a   = (c == C_BEL) ? 16'd0 : c;
        q_job.res.act = (c == C_BEL) ? A_TITLE_END : A_TITLE_CH;
      end else begin
        len_nxt = (fail && c == C_ESC) ? '0 : len_n;
        if (is_dig && (mode_r == M_CSI || mode_r == M_CSIQ || mode_r == M_OSC)) begin
          acc_nxt  = {12'd0, c[3:0]};
          pcnt_nxt = PW'(1);
        end else if (is_dig) begin
          acc_nxt = acc_up;
        end
        if (mode_r == M_CSIP && c == C_SEMI && !fail) begin
          ps_we    = 1'b1;
          acc_nxt  = 16'd0;
          pcnt_nxt = pcnt_r + PW'(1);
        end
        if (mode_r == M_CSIQP && !fail && !is_dig) begin
          q_push        = 1'b1;
          q_job.res.act = (acc_r == 16'd12) ? A_BLINK : A_VISIBLE;
          q_job.res.a   = {15'd0, c == C_LH};
        end
        if (fin_csi) begin
          ps_we = 1'b1;
          if (mode_r == M_CSI) begin
            ps_idx   = '0;
            ps_dat   = 16'd0;
            pcnt_nxt = PW'(1);
          end
          q_push      = 1'b1;
          q_job.res.b = 16'd0;
          case (c)
            C_UC: begin
              q_job.res.act = A_FWD;
              q_job.res.a   = (p0 == 16'd0) ? 16'd1 : p0;
            end
            C_UH: begin
              q_job.res.act = A_POS;
              q_job.res.a   = (p1 == 16'd0) ? 16'd0 : p1 - 16'd1;
              q_job.res.b   = (p0 == 16'd0) ? 16'd0 : p0 - 16'd1;
            end
            C_UJ: begin
              q_push        = (p0 <= 16'd2);
              q_job.res.act = A_ERASE_D;
              q_job.res.a   = p0;
            end
            C_UX: begin
              q_job.res.act = A_ERASE_C;
              q_job.res.a   = p0;
            end
            default: begin
              q_job.kind = J_SGR;
              q_job.cnt  = CW'(fcnt);
            end
          endcase
        end
        if (fail || ovl) begin
          q_push     = 1'b1;
          q_job.kind = J_FB;
          q_job.cnt  = CW'(fail ? fb_len : len_n);
        end
      end
    end
    busy_nxt = busy_r;
    if (bstat.store_done) busy_nxt = 1'b0;
    if (q_push && q_job.kind != J_ONE) busy_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_ECHO;
      len_r  <= '0;
      pcnt_r <= '0;
      busy_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      len_r  <= len_nxt;
      pcnt_r <= pcnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (ps_we) pstore_r[ps_idx] <= ps_dat;
  end

  a_busy_mode: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (mode_r == M_ECHO || mode_r == M_ESC))
    else $error("front busy outside echo or escape state");
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(SEQ_CHARS))
    else $error("sequence length beyond store");

endmodule
`default_nettype wire

// ===== src/aesp_back.sv =====
// aesp_back: expands queued jobs into action words, holds the sequence store.
// Depends on aesp_pkg; fed by aesp_jobq and aesp_front.
`default_nettype none
module aesp_back
  import aesp_pkg::*;
#(
  parameter int MAX_PARAMS = 16,
  parameter int SEQ_CHARS  = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          q_empty,
  input  job_t                         q_job,
  output logic                         q_pop,
  input  seq_wr_t                      seq_wr,
  input  wire  [MAX_PARAMS-1:0][15:0]  pvals,
  output bstat_t                       bstat,
  output logic                         out_empty,
  input  wire                          out_pop,
  output logic [3:0]                   out_action,
  output logic [15:0]                  out_arg_a,
  output logic [15:0]                  out_arg_b,
  output logic                         out_last
);

  localparam int SIW = $clog2(SEQ_CHARS);
  localparam int PIW = $clog2(MAX_PARAMS);

  logic [15:0]   seq_mem [SEQ_CHARS];
  logic [15:0]   rdata_r;
  bstate_t       st_r, st_nxt;
  job_t          job_r;
  logic [CW-1:0] idx_r, idx_p1;
  logic          sub_r;
  logic          hold_v_r, ov_r, olast_r;
  res_t          hold_r, ovd_r, gen;
  logic          gen_v, fire, end_ok, out_free, opop, can_take, pdone;
  logic [15:0]   p;

  assign out_free = !ov_r || out_pop;
  assign opop     = out_pop && ov_r;
  assign can_take = !hold_v_r || out_free;
  assign end_ok   = (st_r == B_END) && can_take;
  assign fire     = gen_v ? can_take : 1'b1;
  assign idx_p1   = idx_r + CW'(1);
  assign p        = pvals[idx_r[PIW-1:0]];
  assign pdone    = !((p == 16'd0) && !sub_r);
  assign q_pop    = (st_r == B_IDLE) && !q_empty;
  assign bstat.store_done = end_ok && (job_r.kind != J_ONE);

  assign out_empty  = !ov_r;
  assign out_action = ovd_r.act;
  assign out_arg_a  = ovd_r.a;
  assign out_arg_b  = ovd_r.b;
  assign out_last   = olast_r;

  // generated word
  always_comb begin
    gen_v = 1'b0;
    gen   = '{act: A_WRITE, a: 16'd0, b: 16'd0};
    case (st_r)
      B_ONE: begin
        gen_v = 1'b1;
        gen   = job_r.res;
      end
      B_ESC: begin
        gen_v = 1'b1;
        gen.a = (idx_r == CW'(0)) ? C_UE : ((idx_r == CW'(1)) ? C_US : C_UC);
      end
      B_CH: begin
        gen_v = 1'b1;
        gen   = echo_res(rdata_r);
      end
      B_SGR: begin
        gen_v = 1'b1;
        if (p == 16'd0) begin
          gen.act = sub_r ? A_FG : A_RST_ATTR;
          gen.a   = sub_r ? COL_DEF : 16'd0;
        end else if (p inside {[16'd30:16'd37]}) begin
          gen.act = A_FG;
          gen.a   = p - 16'd30;
        end else if (p == 16'd39) begin
          gen.act = A_FG;
          gen.a   = COL_DEF;
        end else if (p inside {[16'd40:16'd47]}) begin
          gen.act = A_BG;
          gen.a   = p - 16'd40;
        end else if (p == 16'd49) begin
          gen.act = A_BG;
          gen.a   = COL_DEF;
        end else if (p inside {[16'd90:16'd97]}) begin
          gen.act = A_FG;
          gen.a   = p - 16'd82;
        end else if (p inside {[16'd100:16'd107]}) begin
          gen.act = A_BG;
          gen.a   = p - 16'd92;
        end else begin
          gen_v = 1'b0;
        end
      end
      default: gen_v = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      B_IDLE: begin
        if (!q_empty) begin
          case (q_job.kind)
            J_ONE:   st_nxt = B_ONE;
            J_FB:    st_nxt = B_ESC;
            J_SGR:   st_nxt = (q_job.cnt == '0) ? B_END : B_SGR;
            default: st_nxt = B_IDLE;
          endcase
        end
      end
      B_ONE: if (fire) st_nxt = B_END;
      B_ESC: if (fire && idx_r == CW'(2)) st_nxt = (job_r.cnt == '0) ? B_END : B_RD;
      B_RD:  st_nxt = B_CH;
      B_CH:  if (fire) st_nxt = (idx_p1 == job_r.cnt) ? B_END : B_RD;
      B_SGR: if (fire && pdone && idx_p1 == job_r.cnt) st_nxt = B_END;
      B_END: if (end_ok) st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= B_IDLE;
      hold_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (gen_v && fire) begin
        hold_v_r <= 1'b1;
        if (hold_v_r) ov_r <= 1'b1;
        else if (opop) ov_r <= 1'b0;
      end else if (end_ok && hold_v_r) begin
        hold_v_r <= 1'b0;
        ov_r     <= 1'b1;
      end else if (opop) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
      idx_r <= '0;
      sub_r <= 1'b0;
    end else if (fire) begin
      case (st_r)
        B_ESC: idx_r <= (idx_r == CW'(2)) ? '0 : idx_p1;
        B_CH:  idx_r <= idx_p1;
        B_SGR: begin
          if (pdone) idx_r <= idx_p1;
          sub_r <= !pdone;
        end
        default: idx_r <= idx_r;
      endcase
    end
    if (gen_v && fire) begin
      hold_r <= gen;
      if (hold_v_r) begin
        ovd_r   <= hold_r;
        olast_r <= 1'b0;
      end
    end else if (end_ok && hold_v_r) begin
      ovd_r   <= hold_r;
      olast_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_wr.we) seq_mem[seq_wr.addr[SIW-1:0]] <= seq_wr.data;
    rdata_r <= seq_mem[idx_r[SIW-1:0]];
  end

  a_idle_flushed: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == B_IDLE |-> !hold_v_r)
    else $error("held word left behind at job end");
  a_read_first: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == B_CH |-> ($past(st_r) == B_RD || $past(st_r) == B_CH))
    else $error("replayed character used before its read");
  a_out_kept: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_pop |=> ov_r)
    else $error("result word dropped before it was taken");

endmodule
`default_nettype wire

// ===== src/ansi_escape_sequence_parser.sv =====
// ansi_escape_sequence_parser: top level, front parser, job queue and back end.
// Depends on aesp_pkg, aesp_front, aesp_jobq, aesp_back.
//
//   channel | ports                                  | direction
//   input   | in_push, in_full, in_ch                | character words in
//   result  | out_pop, out_empty, out_action,        | action words out
//           | out_arg_a, out_arg_b, out_last         |
//
// The front takes one character per cycle while the job queue has room.
// A single-action job passes through pop, emit and release in the back end,
// which takes a new job only after releasing the last; a fallback writes E, S, C
// then reads and replays each stored character, paced by the sequence store read
// port, and a rendition emits one word per known parameter (two for a zero).
// While a fallback or rendition job runs, in_full stays high.
// Synchronous active-low reset; no clearing pass. An out_pop held low stalls the
// back end, the job queue then fills and in_full rises.
`default_nettype none
module ansi_escape_sequence_parser
  import aesp_pkg::*;
#(
  parameter int MAX_PARAMS = 16,
  parameter int SEQ_CHARS  = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_push,
  input  wire  [15:0] in_ch,
  output logic        in_full,
  output logic        out_empty,
  input  wire         out_pop,
  output logic [3:0]  out_action,
  output logic [15:0] out_arg_a,
  output logic [15:0] out_arg_b,
  output logic        out_last
);

  logic                        q_full, q_push, q_pop, q_empty;
  job_t                        q_din, q_dout;
  seq_wr_t                     seq_wr;
  logic [MAX_PARAMS-1:0][15:0] pvals;
  bstat_t                      bstat;

  aesp_front #(.MAX_PARAMS(MAX_PARAMS), .SEQ_CHARS(SEQ_CHARS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_ch   (in_ch),
    .in_full (in_full),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (q_din),
    .seq_wr  (seq_wr),
    .pvals   (pvals),
    .bstat   (bstat)
  );

  aesp_jobq u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  aesp_back #(.MAX_PARAMS(MAX_PARAMS), .SEQ_CHARS(SEQ_CHARS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_job      (q_dout),
    .q_pop      (q_pop),
    .seq_wr     (seq_wr),
    .pvals      (pvals),
    .bstat      (bstat),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_action (out_action),
    .out_arg_a  (out_arg_a),
    .out_arg_b  (out_arg_b),
    .out_last   (out_last)
  );

endmodule
`default_nettype wire
